>>> rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Types, constants and the lane divide-by-ten helper for the decimal
// round-to-integer block.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  localparam int MAG_W    = 96;
  localparam int SCALE_W  = 5;
  localparam int MODE_W   = 2;
  localparam int LANE_W   = 16;
  localparam int LANES    = MAG_W / LANE_W;
  localparam int REM_W    = 4;
  localparam int X_W      = LANE_W + REM_W;
  localparam int RECIP_W  = 19;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam int RECIP_SH = 22;

  // ceil(2^22 / 10); exact quotient for any x below 10 * 2^16
  localparam logic [RECIP_W-1:0] RECIP_TEN = 19'd419431;

  localparam logic [REM_W-1:0] DIGIT_HALF = 4'd5;

  localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLOOR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROUND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEGATE = 2'd3;

  typedef logic [LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic [LANE_W-1:0] q;
    logic [REM_W-1:0]  r;
  } lane_div_t;

  typedef struct packed {
    logic             load;
    logic [LANES-1:0] step;
    logic             inc;
    logic             publish;
  } drt_cmd_t;

  typedef struct packed {
    logic [SCALE_W-1:0] div_count;
  } drt_stat_t;

  // x = rem * 2^16 + lane, rem < 10
  function automatic lane_div_t lane_div10(input logic [X_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    back;
    lane_div_t         res;
    prod  = PROD_W'(x) * PROD_W'(RECIP_TEN);
    res.q = prod[RECIP_SH +: LANE_W];
    back  = {1'b0, res.q, 3'b000} + {3'b000, res.q, 1'b0};
    res.r = REM_W'(x - back);
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/drt_ctrl.sv
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: accepts an item, runs the divide wavefront across the lanes,
// issues the increment step and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_ctrl
  import drt_pkg::*;
#(
  parameter int MAX_SCALE = 28
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire drt_stat_t stat,
  output drt_cmd_t       cmd
);

  localparam int CNT_W = $clog2(MAX_SCALE + LANES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_INC,
    S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cyc;
  logic [CNT_W-1:0]  div_cnt;
  logic              div_end;

  assign div_cnt = CNT_W'(stat.div_count);
  assign div_end = (stat.div_count == '0) || (cyc == div_cnt + CNT_W'(LANES - 2));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.load    = in_valid && (state == S_IDLE);
    cmd.inc     = (state == S_INC);
    cmd.publish = (state == S_DONE) && (!out_valid || !out_stall);
    for (int k = 0; k < LANES; k++) begin
      // lane k runs one step behind the lane above it
      cmd.step[k] = (state == S_DIV) && (cyc >= CNT_W'(LANES - 1 - k)) &&
                    (cyc < div_cnt + CNT_W'(LANES - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cyc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cyc <= '0;
          if (in_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cyc <= cyc + 1'b1;
          if (div_end) begin
            state <= S_INC;
          end
        end
        S_INC: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/drt_dpath.sv
// ----------------------------------------------------------------------------
// drt_dpath
// Six 16-bit lanes, each with its own divide-by-ten unit, a sticky digit
// flag, the 96-bit increment and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_dpath
  import drt_pkg::*;
#(
  parameter int MAX_SCALE = 28
) (
  input  wire logic               clk,
  input  wire drt_cmd_t           cmd,
  output drt_stat_t               stat,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [63:0]        magnitude_low,
  input  wire logic [31:0]        magnitude_high,
  input  wire logic               negative,
  input  wire logic [SCALE_W-1:0] scale,
  output logic [63:0]             out_magnitude_low,
  output logic [31:0]             out_magnitude_high,
  output logic                    out_negative,
  output logic [SCALE_W-1:0]      out_scale
);

  localparam logic [SCALE_W-1:0] SCALE_LIM = SCALE_W'(MAX_SCALE);

  lanes_t                       lane;
  logic [LANES-1:0][REM_W-1:0]  rem;
  logic                         sticky;
  logic [MODE_W-1:0]            mode_q;
  logic                         neg_q;
  logic [SCALE_W-1:0]           scale_q;
  logic [SCALE_W-1:0]           div_count;
  logic [SCALE_W-1:0]           scale_sat;
  logic                         inc_hit;
  logic [MAG_W-1:0]             mag_inc;
  lane_div_t [LANES-1:0]        dres;

  assign scale_sat = (scale > SCALE_LIM) ? SCALE_LIM : scale;
  assign stat.div_count = div_count;
  assign mag_inc = lane + MAG_W'(1);

  always_comb begin
    case (mode_q)
      MODE_FLOOR: inc_hit = neg_q && sticky;
      MODE_ROUND: inc_hit = (div_count != '0) && (rem[0] >= DIGIT_HALF);
      default:    inc_hit = 1'b0;
    endcase
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [REM_W-1:0] rem_in;
    if (k == LANES - 1) begin : g_top
      assign rem_in = '0;
    end else begin : g_mid
      assign rem_in = rem[k+1];
    end
    assign dres[k] = lane_div10({rem_in, lane[k]});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lane      <= {magnitude_high, magnitude_low};
      rem       <= '0;
      sticky    <= 1'b0;
      mode_q    <= mode;
      neg_q     <= negative;
      scale_q   <= scale_sat;
      div_count <= (mode == MODE_NEGATE) ? '0 : scale_sat;
    end else begin
      for (int k = 0; k < LANES; k++) begin
        if (cmd.step[k]) begin
          lane[k] <= dres[k].q;
          rem[k]  <= dres[k].r;
        end
      end
      if (cmd.step[0] && (dres[0].r != '0)) begin
        sticky <= 1'b1;
      end
      if (cmd.inc && inc_hit) begin
        lane <= mag_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      {out_magnitude_high, out_magnitude_low} <= lane;
      if (mode_q == MODE_NEGATE) begin
        out_negative <= ~neg_q;
        out_scale    <= scale_q;
      end else begin
        out_negative <= neg_q;
        out_scale    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/decimal_round_to_integer.sv
// ----------------------------------------------------------------------------
// decimal_round_to_integer
// Rounds a scaled 96-bit decimal to an integer (truncate, floor, round half
// away from zero) or negates it.
//
// Input channel: in_valid / in_stall with mode, magnitude_low/high, negative
// and scale. Output channel: out_valid / out_stall with the out_* fields.
// One result per item, in order.
// The magnitude is held as six 16-bit lanes, each with its own divide-by-ten
// unit. A division step ripples down the lanes, each lane taking it in the
// cycle after the lane above, so a new step starts every cycle.
// The division count is the saturated scale (none in negate mode).
// The next item is accepted in the cycle after the result moves to the output
// register, so the block takes no new item before the last one is done.
// The output register holds the result while out_stall is high; the block
// finishes the following item and waits for the register to free up.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_round_to_integer
  import drt_pkg::*;
#(
  parameter int MAX_SCALE = 28
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [63:0]        magnitude_low,
  input  wire logic [31:0]        magnitude_high,
  input  wire logic               negative,
  input  wire logic [SCALE_W-1:0] scale,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             out_magnitude_low,
  output logic [31:0]             out_magnitude_high,
  output logic                    out_negative,
  output logic [SCALE_W-1:0]      out_scale
);

  drt_cmd_t  cmd;
  drt_stat_t stat;

  drt_ctrl #(
    .MAX_SCALE (MAX_SCALE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  drt_dpath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dpath (
    .clk                (clk),
    .cmd                (cmd),
    .stat               (stat),
    .mode               (mode),
    .magnitude_low      (magnitude_low),
    .magnitude_high     (magnitude_high),
    .negative           (negative),
    .scale              (scale),
    .out_magnitude_low  (out_magnitude_low),
    .out_magnitude_high (out_magnitude_high),
    .out_negative       (out_negative),
    .out_scale          (out_scale)
  );

endmodule

`default_nettype wire

>>> rtl/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks for decimal_round_to_integer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_checker
  import drt_pkg::*;
#(
  parameter int MAX_SCALE = 28
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [63:0]        out_magnitude_low,
  input wire logic [31:0]        out_magnitude_high,
  input wire logic               out_negative,
  input wire logic [SCALE_W-1:0] out_scale
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  // a result appears only after the block was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_scale <= SCALE_W'(MAX_SCALE))
    else $error("output scale above limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude_low) &&
      $stable(out_magnitude_high) && $stable(out_negative) && $stable(out_scale))
    else $error("stalled result changed");

endmodule

bind decimal_round_to_integer drt_checker #(.MAX_SCALE(MAX_SCALE)) u_drt_checker (.*);

`default_nettype wire

>>> verif/decimal_round_to_integer_test.sv
// ----------------------------------------------------------------------------
// decimal_round_to_integer_test
// Self-checking bench for the decimal round-to-integer block. Items go in
// through a valid/stall channel. A 96-bit model of the divide-by-ten rounding
// predicts each result, and a scoreboard compares results field by field, in
// order. A directed set covers the extremes, the floor sticky digit, the
// rounding half point and the scale cap. Random items then run under four
// idling profiles on the input and output sides.
// ----------------------------------------------------------------------------

module decimal_round_to_integer_test;
  import drt_pkg::*;

  localparam int SCALE_CAP = 28;
  localparam int PHASE_ITEMS = 345;

  typedef struct {
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [SCALE_W-1:0] scl;
  } rounded_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode = MODE_TRUNC;
  logic [63:0]         magnitude_low = '0;
  logic [31:0]         magnitude_high = '0;
  logic                negative = 1'b0;
  logic [SCALE_W-1:0]  scale = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [63:0]         out_magnitude_low;
  logic [31:0]         out_magnitude_high;
  logic                out_negative;
  logic [SCALE_W-1:0]  out_scale;

  rounded_t pending_rounded[$];
  int       mismatch_count = 0;
  int       checked_count = 0;
  int       sent_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;

  decimal_round_to_integer #(.MAX_SCALE(SCALE_CAP)) uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .magnitude_low      (magnitude_low),
    .magnitude_high     (magnitude_high),
    .negative           (negative),
    .scale              (scale),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_magnitude_low  (out_magnitude_low),
    .out_magnitude_high (out_magnitude_high),
    .out_negative       (out_negative),
    .out_scale          (out_scale)
  );

  always #10 clk = ~clk;

  function automatic logic [MAG_W-1:0] pow_ten(input int n);
    logic [MAG_W-1:0] p;
    p = MAG_W'(1);
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic rounded_t predict_rounding(input logic [MODE_W-1:0] md,
                                                input logic [MAG_W-1:0] mag,
                                                input logic neg,
                                                input logic [SCALE_W-1:0] scl);
    rounded_t         r;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] digit;
    logic             sticky;
    int               eff;
    eff = (scl > SCALE_CAP) ? SCALE_CAP : int'(scl);
    m = mag;
    digit = '0;
    sticky = 1'b0;
    if (md == MODE_NEGATE) begin
      r.mag = mag;
      r.neg = ~neg;
      r.scl = SCALE_W'(eff);
      return r;
    end
    for (int i = 0; i < eff; i++) begin
      digit = m % 10;
      m = m / 10;
      if (digit != 0) sticky = 1'b1;
    end
    if (md == MODE_FLOOR && neg && sticky) begin
      m = m + 1;
    end else if (md == MODE_ROUND && eff != 0 && digit >= DIGIT_HALF) begin
      m = m + 1;
    end
    r.mag = m;
    r.neg = neg;
    r.scl = '0;
    return r;
  endfunction

  // sender side idles before the item at idle_pct percent per cycle
  task automatic send_item(input logic [MODE_W-1:0] md, input logic [MAG_W-1:0] mag,
                           input logic neg, input logic [SCALE_W-1:0] scl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode <= md;
    magnitude_low <= mag[63:0];
    magnitude_high <= mag[95:64];
    negative <= neg;
    scale <= scl;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_rounded.push_back(predict_rounding(md, mag, neg, scl));
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [MAG_W-1:0] random_magnitude(input logic [SCALE_W-1:0] scl);
    logic [MAG_W-1:0] unit;
    logic [MAG_W-1:0] k;
    int               eff;
    eff = (scl > SCALE_CAP) ? SCALE_CAP : int'(scl);
    unit = pow_ten(eff);
    k = {$urandom, $urandom, $urandom};
    case ($urandom_range(5))
      0: return k;
      1: return MAG_W'($urandom_range(999));
      2: return (k % 7) * unit + (unit / 10) * 5 - MAG_W'($urandom_range(1));
      3: return (k % 1000) * unit + MAG_W'($urandom_range(1));
      4: return ~MAG_W'($urandom_range(999));
      default: return {32'h0, $urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    rounded_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rounded.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h neg=%b scale=%0d", $time,
                 out_magnitude_low, out_magnitude_high, out_negative, out_scale);
        mismatch_count++;
      end else begin
        want = pending_rounded.pop_front();
        checked_count++;
        if (out_magnitude_low !== want.mag[63:0]) begin
          $display("%0t: magnitude_low expected %h got %h", $time, want.mag[63:0],
                   out_magnitude_low);
          mismatch_count++;
        end
        if (out_magnitude_high !== want.mag[95:64]) begin
          $display("%0t: magnitude_high expected %h got %h", $time, want.mag[95:64],
                   out_magnitude_high);
          mismatch_count++;
        end
        if (out_negative !== want.neg) begin
          $display("%0t: negative expected %b got %b", $time, want.neg, out_negative);
          mismatch_count++;
        end
        if (out_scale !== want.scl) begin
          $display("%0t: scale expected %0d got %0d", $time, want.scl, out_scale);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    logic [MODE_W-1:0] md;
    for (int i = 0; i < 4; i++) begin
      md = MODE_W'(i);
      send_item(md, '1, 1'b1, 5'd0);
      send_item(md, '1, 1'b0, 5'd28);
    end
    // negative zero survives truncation
    send_item(MODE_TRUNC, '0, 1'b1, 5'd5);
    send_item(MODE_ROUND, '1, 1'b1, 5'd31);
  endtask

  task automatic test_floor_sticky();
    // nonzero digit below the top dropped digit
    send_item(MODE_FLOOR, 96'd101, 1'b1, 5'd2);
    send_item(MODE_FLOOR, 96'd101, 1'b0, 5'd2);
    send_item(MODE_FLOOR, 96'd100, 1'b1, 5'd2);
    send_item(MODE_FLOOR, 96'd7, 1'b1, 5'd0);
  endtask

  task automatic test_round_half();
    send_item(MODE_ROUND, 96'd15, 1'b0, 5'd1);
    send_item(MODE_ROUND, 96'd14, 1'b0, 5'd1);
    send_item(MODE_ROUND, 96'd149, 1'b0, 5'd2);
    send_item(MODE_ROUND, 96'd150, 1'b0, 5'd2);
    send_item(MODE_ROUND, 96'd25, 1'b1, 5'd1);
    send_item(MODE_ROUND, 96'd9, 1'b0, 5'd0);
  endtask

  task automatic test_negate_saturate();
    send_item(MODE_NEGATE, 96'd12345, 1'b1, 5'd31);
    send_item(MODE_NEGATE, 96'd678, 1'b0, 5'd29);
    send_item(MODE_NEGATE, '0, 1'b0, 5'd0);
  endtask

  task automatic test_random(input int n, input int sender_idle, input int receiver_stall);
    logic [SCALE_W-1:0] scl;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < n; i++) begin
      scl = ($urandom_range(9) == 0) ? SCALE_W'($urandom_range(31, 29))
                                     : SCALE_W'($urandom_range(28));
      send_item(MODE_W'($urandom_range(3)), random_magnitude(scl), 1'($urandom_range(1)),
                scl);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_floor_sticky();
    test_round_half();
    test_negate_saturate();
    test_random(PHASE_ITEMS, 0, 0);
    test_random(PHASE_ITEMS, 75, 0);
    test_random(PHASE_ITEMS, 0, 75);
    test_random(PHASE_ITEMS, 20, 20);
    in_valid <= 1'b0;
    while (pending_rounded.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items (all modes, scales 0 to 31, four idling profiles);", sent_count);
    $display("checked %0d results, %0d field errors.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out with %0d results pending.", pending_rounded.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
